>>> design/bpa_pkg.sv
// bpa_pkg: shared types and constants of the buddy page allocator
// no dependencies

package bpa_pkg;

    localparam int MAX_ORDER = 10;
    localparam int NPAGES    = 1 << MAX_ORDER;
    localparam int NLISTS    = MAX_ORDER + 1;
    localparam int PW        = MAX_ORDER;          // page index width
    localparam int NW        = MAX_ORDER + 1;      // link node width, msb marks a list header
    localparam int OW        = 4;                  // order field width
    localparam int LW        = $clog2(NLISTS);     // list index width

    typedef logic [PW-1:0] t_page;
    typedef logic [NW-1:0] t_node;
    typedef logic [OW-1:0] t_ord;
    typedef logic [LW-1:0] t_lidx;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_UNLINK,
        OP_SPLIT,
        OP_ALLOC_FIN,
        OP_FREE_INIT,
        OP_FAIL_FREE,
        OP_BUD_READ,
        OP_MERGE,
        OP_PUSH1,
        OP_PUSH2
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic rd_free;
        logic ord_is_max;
        logic ord_gt_req;
        logic bud_match;
    } t_sts;

endpackage

>>> design/bpa_ctrl.sv
// bpa_ctrl: sequencing state machine of the buddy page allocator
// depends on bpa_pkg

module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_action,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd,
    output logic          busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_UNL,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_F_BUD,
        S_F_PUSH2
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = bpa_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = bpa_pkg::OP_LATCH;
                    if (i_action) begin
                        n_state = S_F_RD;
                    end else if (i_sts.found) begin
                        n_state = S_A_UNL;
                    end
                end
            end
            S_A_UNL: begin
                o_cmd.op = bpa_pkg::OP_UNLINK;
                n_state  = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                if (i_sts.ord_gt_req) begin
                    o_cmd.op = bpa_pkg::OP_SPLIT;
                end else begin
                    o_cmd.op = bpa_pkg::OP_ALLOC_FIN;
                    n_state  = S_IDLE;
                end
            end
            S_F_RD: begin
                if (i_sts.rd_free) begin
                    o_cmd.op = bpa_pkg::OP_FAIL_FREE;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_FREE_INIT;
                    n_state  = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_sts.ord_is_max) begin
                    o_cmd.op = bpa_pkg::OP_PUSH1;
                    n_state  = S_F_PUSH2;
                end else begin
                    o_cmd.op = bpa_pkg::OP_BUD_READ;
                    n_state  = S_F_BUD;
                end
            end
            S_F_BUD: begin
                if (i_sts.bud_match) begin
                    o_cmd.op = bpa_pkg::OP_MERGE;
                    n_state  = S_F_CHK;
                end else begin
                    o_cmd.op = bpa_pkg::OP_PUSH1;
                    n_state  = S_F_PUSH2;
                end
            end
            S_F_PUSH2: begin
                o_cmd.op = bpa_pkg::OP_PUSH2;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> design/bpa_dp.sv
// bpa_dp: page table memories, list heads and result registers
// depends on bpa_pkg

module bpa_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpa_pkg::t_cmd         i_cmd,
    input  logic                  i_action,
    input  bpa_pkg::t_ord         i_order,
    input  bpa_pkg::t_page        i_page,
    output bpa_pkg::t_sts         o_sts,
    output logic                  o_done,
    output logic                  o_status,
    output bpa_pkg::t_page        o_result_page,
    output bpa_pkg::t_ord         o_result_order
);

    localparam int PW = bpa_pkg::PW;
    localparam bpa_pkg::t_ord MAXO = bpa_pkg::t_ord'(bpa_pkg::MAX_ORDER);

    function automatic bpa_pkg::t_node hdr(input bpa_pkg::t_ord k);
        hdr = {1'b1, PW'(k)};
    endfunction

    function automatic logic hdr_ok(input bpa_pkg::t_node n);
        hdr_ok = n[PW] && (n[PW-1:0] < PW'(bpa_pkg::NLISTS));
    endfunction

    // page table: {free, order}, next link, prev link
    logic [bpa_pkg::OW:0] mem_fo [bpa_pkg::NPAGES];
    bpa_pkg::t_node       mem_nx [bpa_pkg::NPAGES];
    bpa_pkg::t_node       mem_pv [bpa_pkg::NPAGES];

    bpa_pkg::t_node r_first [bpa_pkg::NLISTS];
    bpa_pkg::t_node r_last  [bpa_pkg::NLISTS];

    logic                 r_v_fo, r_v_nx, r_v_pv, r_rd0;
    logic [bpa_pkg::OW:0] r_rd_fo;
    bpa_pkg::t_node       r_rd_nx, r_rd_pv;
    bpa_pkg::t_ord        r_req, r_ord;
    bpa_pkg::t_page       r_cur, r_bud;
    logic                 r_done, r_status;
    bpa_pkg::t_page       r_res_page;
    bpa_pkg::t_ord        r_res_ord;

    logic [bpa_pkg::OW:0] rd_fo;
    bpa_pkg::t_node       rd_nx, rd_pv;
    bpa_pkg::t_page       rd_addr;
    logic                 fo_we, nx_we, pv_we;
    bpa_pkg::t_page       fo_wa, nx_wa, pv_wa;
    logic [bpa_pkg::OW:0] fo_wd;
    bpa_pkg::t_node       nx_wd, pv_wd;
    logic                 found;
    bpa_pkg::t_lidx       sel;
    bpa_pkg::t_ord        ord_m1, ord_p1;
    bpa_pkg::t_page       split_b, bud_b;
    bpa_pkg::t_lidx       ord_ix;

    // entry 0 reads as the single top block until written
    assign rd_fo = (r_rd0 && !r_v_fo) ? {1'b1, MAXO} : r_rd_fo;
    assign rd_nx = (r_rd0 && !r_v_nx) ? hdr(MAXO) : r_rd_nx;
    assign rd_pv = (r_rd0 && !r_v_pv) ? hdr(MAXO) : r_rd_pv;

    // smallest non-empty list at or above the requested order
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = bpa_pkg::NLISTS - 1; k >= 0; k--) begin
            if (!r_first[k][PW] && (bpa_pkg::t_ord'(k) >= i_order)) begin
                found = 1'b1;
                sel   = bpa_pkg::t_lidx'(k);
            end
        end
    end

    assign ord_m1  = r_ord - bpa_pkg::t_ord'(1);
    assign ord_p1  = r_ord + bpa_pkg::t_ord'(1);
    assign ord_ix  = bpa_pkg::t_lidx'(r_ord);
    assign split_b = r_cur + (PW'(1) << ord_m1);
    assign bud_b   = r_cur ^ (PW'(1) << r_ord);

    assign o_sts.found      = found;
    assign o_sts.rd_free    = rd_fo[bpa_pkg::OW];
    assign o_sts.ord_is_max = (r_ord == MAXO);
    assign o_sts.ord_gt_req = (r_ord > r_req);
    assign o_sts.bud_match  = rd_fo[bpa_pkg::OW] && (rd_fo[bpa_pkg::OW-1:0] == r_ord);

    // memory port control
    always_comb begin
        rd_addr = r_cur;
        fo_we = 1'b0; fo_wa = r_cur; fo_wd = '0;
        nx_we = 1'b0; nx_wa = r_cur; nx_wd = '0;
        pv_we = 1'b0; pv_wa = r_cur; pv_wd = '0;
        case (i_cmd.op)
            bpa_pkg::OP_LATCH: begin
                rd_addr = i_action ? i_page : r_first[sel][PW-1:0];
            end
            bpa_pkg::OP_UNLINK, bpa_pkg::OP_MERGE: begin
                nx_we = !rd_pv[PW]; nx_wa = rd_pv[PW-1:0]; nx_wd = rd_nx;
                pv_we = !rd_nx[PW]; pv_wa = rd_nx[PW-1:0]; pv_wd = rd_pv;
            end
            bpa_pkg::OP_SPLIT: begin
                fo_we = 1'b1; fo_wa = split_b; fo_wd = {1'b1, ord_m1};
                nx_we = 1'b1; nx_wa = split_b; nx_wd = hdr(ord_m1);
                pv_we = 1'b1; pv_wa = split_b; pv_wd = hdr(ord_m1);
            end
            bpa_pkg::OP_ALLOC_FIN: begin
                fo_we = 1'b1; fo_wd = {1'b0, r_req};
            end
            bpa_pkg::OP_BUD_READ: begin
                rd_addr = bud_b;
            end
            bpa_pkg::OP_PUSH1: begin
                fo_we = 1'b1; fo_wd = {1'b1, r_ord};
                nx_we = 1'b1; nx_wd = r_first[ord_ix];
                pv_we = !r_first[ord_ix][PW];
                pv_wa = r_first[ord_ix][PW-1:0];
                pv_wd = {1'b0, r_cur};
            end
            bpa_pkg::OP_PUSH2: begin
                pv_we = 1'b1; pv_wd = hdr(r_ord);
            end
            default: begin
                rd_addr = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fo_we) mem_fo[fo_wa] <= fo_wd;
        if (nx_we) mem_nx[nx_wa] <= nx_wd;
        if (pv_we) mem_pv[pv_wa] <= pv_wd;
        r_rd_fo <= mem_fo[rd_addr];
        r_rd_nx <= mem_nx[rd_addr];
        r_rd_pv <= mem_pv[rd_addr];
        r_rd0   <= (rd_addr == '0);
    end

    // control state: valid bits of entry 0, list heads, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_fo <= 1'b0;
            r_v_nx <= 1'b0;
            r_v_pv <= 1'b0;
            r_done <= 1'b0;
            for (int k = 0; k < bpa_pkg::NLISTS; k++) begin
                r_first[k] <= (k == bpa_pkg::MAX_ORDER) ? '0 : hdr(bpa_pkg::t_ord'(k));
                r_last[k]  <= (k == bpa_pkg::MAX_ORDER) ? '0 : hdr(bpa_pkg::t_ord'(k));
            end
        end else begin
            if (fo_we && fo_wa == '0) r_v_fo <= 1'b1;
            if (nx_we && nx_wa == '0) r_v_nx <= 1'b1;
            if (pv_we && pv_wa == '0) r_v_pv <= 1'b1;
            r_done <= 1'b0;
            case (i_cmd.op)
                bpa_pkg::OP_LATCH: begin
                    r_done <= !i_action && !found;
                end
                bpa_pkg::OP_UNLINK, bpa_pkg::OP_MERGE: begin
                    if (hdr_ok(rd_pv)) r_first[bpa_pkg::t_lidx'(rd_pv[PW-1:0])] <= rd_nx;
                    if (hdr_ok(rd_nx)) r_last[bpa_pkg::t_lidx'(rd_nx[PW-1:0])]  <= rd_pv;
                end
                bpa_pkg::OP_SPLIT: begin
                    r_first[bpa_pkg::t_lidx'(ord_m1)] <= {1'b0, split_b};
                    r_last[bpa_pkg::t_lidx'(ord_m1)]  <= {1'b0, split_b};
                end
                bpa_pkg::OP_ALLOC_FIN, bpa_pkg::OP_FAIL_FREE, bpa_pkg::OP_PUSH2: begin
                    r_done <= 1'b1;
                    if (i_cmd.op == bpa_pkg::OP_PUSH2) r_first[ord_ix] <= {1'b0, r_cur};
                end
                bpa_pkg::OP_PUSH1: begin
                    if (hdr_ok(r_first[ord_ix])) begin
                        r_last[bpa_pkg::t_lidx'(r_first[ord_ix][PW-1:0])] <= {1'b0, r_cur};
                    end
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bpa_pkg::OP_LATCH: begin
                r_req      <= i_order;
                r_cur      <= i_action ? i_page : r_first[sel][PW-1:0];
                r_ord      <= bpa_pkg::t_ord'(sel);
                r_status   <= 1'b1;
                r_res_page <= '0;
                r_res_ord  <= '0;
            end
            bpa_pkg::OP_SPLIT: begin
                r_ord <= ord_m1;
            end
            bpa_pkg::OP_ALLOC_FIN: begin
                r_status   <= 1'b0;
                r_res_page <= r_cur;
                r_res_ord  <= r_req;
            end
            bpa_pkg::OP_FREE_INIT: begin
                r_ord <= (rd_fo[bpa_pkg::OW-1:0] > MAXO) ? MAXO : rd_fo[bpa_pkg::OW-1:0];
            end
            bpa_pkg::OP_FAIL_FREE: begin
                r_status   <= 1'b1;
                r_res_page <= r_cur;
                r_res_ord  <= rd_fo[bpa_pkg::OW-1:0];
            end
            bpa_pkg::OP_BUD_READ: begin
                r_bud <= bud_b;
            end
            bpa_pkg::OP_MERGE: begin
                if (r_bud < r_cur) r_cur <= r_bud;
                r_ord <= ord_p1;
            end
            bpa_pkg::OP_PUSH2: begin
                r_status   <= 1'b0;
                r_res_page <= r_cur;
                r_res_ord  <= r_ord;
            end
            default: begin
                r_bud <= r_bud;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_page  = r_res_page;
    assign o_result_order = r_res_ord;

endmodule

>>> design/buddy_page_allocator_unit.sv
// buddy_page_allocator_unit: allocate fails straight from the search when no list at or above the
// requested order holds a block, else it unlinks the found block and splits it down to that order
// free fails after reading the page entry on a double free, else it merges upward with free
// buddies of equal order and pushes the result on the front of its list; one transaction at a
// time, busy stays high through the split and merge walks and is low again when the result shows
// synchronous active-low reset leaves one free block covering the whole pool, ready at once
// result is shown for one cycle on o_done and cannot be stalled by the receiver

module buddy_page_allocator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  bpa_pkg::t_ord         i_order,
    input  bpa_pkg::t_page        i_page,
    output logic                  o_done,
    output logic                  o_status,
    output bpa_pkg::t_page        o_result_page,
    output bpa_pkg::t_ord         o_result_order
);

    // command from controller, status back from datapath
    bpa_pkg::t_cmd cmd;
    bpa_pkg::t_sts sts;

    // state machine: search, unlink, split walk, buddy check and merge, list push
    bpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // page table memories, per-order list heads and result registers
    bpa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_order        (i_order),
        .i_page         (i_page),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_page  (o_result_page),
        .o_result_order (o_result_order)
    );

    // a result strobe comes only from an accepted or running transaction
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transaction");

    // the controller is back in idle when the result shows
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy during result strobe");

    // a successful result never reports an order above the pool
    a_ord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_status) |-> (o_result_order <= bpa_pkg::t_ord'(bpa_pkg::MAX_ORDER)))
        else $error("result order out of range");

endmodule

>>> tb/buddy_page_allocator_unit_test.sv
// buddy_page_allocator_unit_test: self-checking bench for the buddy page allocator
// depends on bpa_pkg and buddy_page_allocator_unit; predicts every reply from its own page table
`timescale 1ns / 100ps

module buddy_page_allocator_unit_test;

    localparam int MAX_ORDER = bpa_pkg::MAX_ORDER;
    localparam int NPAGES    = bpa_pkg::NPAGES;
    localparam int NLISTS    = bpa_pkg::NLISTS;

    typedef bpa_pkg::t_page t_page;
    typedef bpa_pkg::t_ord  t_ord;

    localparam bit ACT_ALLOC = 1'b0;
    localparam bit ACT_FREE  = 1'b1;
    localparam bit ST_OK     = 1'b0;
    localparam bit ST_FAIL   = 1'b1;
    localparam int HDR_BASE  = NPAGES;      // node numbers at and above this are list headers
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic  status;
        t_page page;
        t_ord  order;
    } t_reply;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    logic  i_action;
    t_ord  i_order;
    t_page i_page;
    logic  o_done;
    logic  o_status;
    t_page o_result_page;
    t_ord  o_result_order;

    buddy_page_allocator_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_order        (i_order),
        .i_page         (i_page),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_page  (o_result_page),
        .o_result_order (o_result_order)
    );

    // shadow page table of the allocator
    bit   pg_free    [NPAGES];
    t_ord pg_order   [NPAGES];
    int   pg_next    [NPAGES];
    int   pg_prev    [NPAGES];
    int   head_first [NLISTS];
    int   head_last  [NLISTS];
    bit   pg_written [NPAGES];      // entry has been written at least once

    t_reply pending_replies[$];     // replies still owed by the block
    t_page  owned_blocks[$];        // pages handed out and not yet returned
    t_page  touched_pages[$];       // pages whose table entries are defined
    int     fail_count;
    int     cycle_count;
    bit     quiet;                  // no sender gaps while set

    // ---------------------------------------------------------------
    // free-list node helpers, pages below HDR_BASE and headers above
    // ---------------------------------------------------------------
    function automatic int node_next(int n);
        if (n < HDR_BASE) return pg_next[n];
        return head_first[n - HDR_BASE];
    endfunction

    function automatic int node_prev(int n);
        if (n < HDR_BASE) return pg_prev[n];
        return head_last[n - HDR_BASE];
    endfunction

    function automatic void set_node_next(int n, int v);
        if (n < HDR_BASE) pg_next[n] = v;
        else head_first[n - HDR_BASE] = v;
    endfunction

    function automatic void set_node_prev(int n, int v);
        if (n < HDR_BASE) pg_prev[n] = v;
        else head_last[n - HDR_BASE] = v;
    endfunction

    function automatic void unlink_block(int p);
        int pv;
        int nx;
        pv = node_prev(p);
        nx = node_next(p);
        set_node_next(pv, nx);
        set_node_prev(nx, pv);
    endfunction

    function automatic void note_write(int p);
        if (!pg_written[p]) begin
            pg_written[p] = 1'b1;
            touched_pages.push_back(t_page'(p));
        end
    endfunction

    // pool state right after reset: one free block covering every page
    function automatic void reset_pool();
        for (int p = 0; p < NPAGES; p++) begin
            pg_free[p]    = 1'b0;
            pg_order[p]   = '0;
            pg_next[p]    = 0;
            pg_prev[p]    = 0;
            pg_written[p] = 1'b0;
        end
        for (int k = 0; k < NLISTS; k++) begin
            head_first[k] = HDR_BASE + k;
            head_last[k]  = HDR_BASE + k;
        end
        touched_pages.delete();
        note_write(0);
        pg_free[0]            = 1'b1;
        pg_order[0]           = t_ord'(MAX_ORDER);
        pg_next[0]            = HDR_BASE + MAX_ORDER;
        pg_prev[0]            = HDR_BASE + MAX_ORDER;
        head_first[MAX_ORDER] = 0;
        head_last[MAX_ORDER]  = 0;
    endfunction

    // allocate: smallest non-empty list at or above req, split down to req
    function automatic t_reply predict_alloc(int req);
        t_reply r;
        int a;
        int p;
        int b;
        a = req;
        while (a <= MAX_ORDER && head_first[a] >= HDR_BASE) a++;
        if (a > MAX_ORDER) begin
            r = '{status: ST_FAIL, page: '0, order: '0};
            return r;
        end
        p = head_first[a];
        unlink_block(p);
        while (a > req) begin
            a--;
            b = (p + (1 << a)) & (NPAGES - 1);
            note_write(b);
            pg_free[b]  = 1'b1;
            pg_order[b] = t_ord'(a);
            pg_next[b]  = HDR_BASE + a;
            pg_prev[b]  = HDR_BASE + a;
            head_first[a] = b;
            head_last[a]  = b;
        end
        note_write(p);
        pg_free[p]  = 1'b0;
        pg_order[p] = t_ord'(req);
        r = '{status: ST_OK, page: t_page'(p), order: t_ord'(req)};
        return r;
    endfunction

    // free: merge upward with free buddies of equal order, then push on the front
    function automatic t_reply predict_free(int pg);
        t_reply r;
        int o;
        int cur;
        int b;
        int fst;
        o   = pg_order[pg];
        cur = pg;
        if (pg_free[pg]) begin
            r = '{status: ST_FAIL, page: t_page'(pg), order: t_ord'(o)};
            return r;
        end
        if (o > MAX_ORDER) o = MAX_ORDER;
        while (o < MAX_ORDER) begin
            b = cur ^ (1 << o);
            if (!(pg_free[b] && pg_order[b] == o)) break;
            unlink_block(b);
            if (b < cur) cur = b;
            o++;
        end
        note_write(cur);
        pg_free[cur]  = 1'b1;
        pg_order[cur] = t_ord'(o);
        fst = head_first[o];
        pg_next[cur] = fst;
        set_node_prev(fst, cur);
        pg_prev[cur] = HDR_BASE + o;
        head_first[o] = cur;
        r = '{status: ST_OK, page: t_page'(cur), order: t_ord'(o)};
        return r;
    endfunction

    // ---------------------------------------------------------------
    // clock, cycle limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // reply checker: every strobe must match the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                $error("reply with nothing outstanding: status %0d page %0d order %0d",
                       o_status, o_result_page, o_result_order);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_result_page !== want.page) begin
                    $error("result_page: expected %0d, got %0d", want.page, o_result_page);
                    fail_count++;
                end
                if (o_result_order !== want.order) begin
                    $error("result_order: expected %0d, got %0d", want.order, o_result_order);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sender: one transaction, with an occasional gap in front of it
    // ---------------------------------------------------------------
    task automatic send_request(input bit act, input int ord, input int pg);
        t_reply r;
        if (!quiet && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_order  <= t_ord'(ord);
        i_page   <= t_page'(pg);
        // accepted at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        if (act == ACT_ALLOC) begin
            r = predict_alloc(ord);
            if (r.status == ST_OK) owned_blocks.push_back(r.page);
        end else begin
            r = predict_free(pg);
        end
        pending_replies.push_back(r);
    endtask

    task automatic go_idle();
        start <= 1'b0;
    endtask

    task automatic alloc_block(input int ord);
        send_request(ACT_ALLOC, ord, $urandom_range(NPAGES - 1));
    endtask

    // hand back a random owned block
    task automatic release_owned();
        int idx;
        t_page pg;
        idx = $urandom_range(owned_blocks.size() - 1);
        pg  = owned_blocks[idx];
        owned_blocks.delete(idx);
        send_request(ACT_FREE, $urandom_range(15), pg);
    endtask

    // free a page already free, only pages with defined entries
    task automatic double_free();
        t_page pg;
        pg = 0;
        for (int t = 0; t < 50; t++) begin
            pg = touched_pages[$urandom_range(touched_pages.size() - 1)];
            if (pg_free[pg]) break;
        end
        if (pg_free[pg]) send_request(ACT_FREE, $urandom_range(15), pg);
    endtask

    task automatic drain_replies();
        go_idle();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        alloc_block(MAX_ORDER);             // whole pool
        alloc_block(0);                     // nothing left
        release_owned();                    // back to one block
        double_free();                      // page 0 again
        alloc_block(15);                    // order beyond the pool
        alloc_block(MAX_ORDER + 1);
        alloc_block(0);                     // splits all the way down
        alloc_block(0);
        alloc_block(1);
        alloc_block(9);
        alloc_block(3);
        alloc_block(2);
        double_free();                      // a split-off buddy
        while (owned_blocks.size() != 0) begin
            send_request(ACT_FREE, 15, owned_blocks.pop_front());
        end
        double_free();
        alloc_block(0);                     // page of every bit pattern later in random part
        alloc_block(MAX_ORDER);             // fails while a page is out
    endtask

    task automatic test_random(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++) begin
            quiet = (i >= n_items / 3) && (i < n_items / 3 + 120);
            pick = $urandom_range(99);
            if (pick < 45 || owned_blocks.size() == 0) begin
                // mostly small orders so the pool stays fragmented but alive
                if ($urandom_range(9) == 0) alloc_block($urandom_range(15));
                else alloc_block($urandom_range(4));
            end else if (pick < 92) begin
                release_owned();
            end else begin
                double_free();
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        alloc_block(0);
        drain_replies();
        alloc_block($urandom_range(MAX_ORDER));
        if (owned_blocks.size() != 0) release_owned();
    endtask

    task automatic test_return_all();
        while (owned_blocks.size() != 0) release_owned();
        alloc_block(MAX_ORDER);             // pool must be whole again
        release_owned();
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        reset_pool();
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_action <= ACT_ALLOC;
        i_order  <= '0;
        i_page   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        test_pause_until_drained();
        test_random(320);
        test_return_all();

        drain_replies();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bpa_pkg.sv
design/bpa_ctrl.sv
design/bpa_dp.sv
design/buddy_page_allocator_unit.sv
tb/buddy_page_allocator_unit_test.sv
